[rtl/tmq_pkg.sv]
// Package: shared transaction types and codes of the timer queue.
`timescale 1ns / 1ps

package tmq_pkg;

    localparam int TIMER_ID_W  = 4;
    localparam int DELAY_W     = 24;
    localparam int OPCODE_W    = 2;
    localparam int KIND_W      = 3;
    // A tick reports at most this many timers.
    localparam int MAX_FIRE    = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_FIRE + 1);

    localparam logic [OPCODE_W-1:0] OP_START  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RSVD   = 2'd3;

    localparam logic [KIND_W-1:0] EV_STARTED     = 3'd0;
    localparam logic [KIND_W-1:0] EV_ALREADY     = 3'd1;
    localparam logic [KIND_W-1:0] EV_CANCELLED   = 3'd2;
    localparam logic [KIND_W-1:0] EV_NOT_PENDING = 3'd3;
    localparam logic [KIND_W-1:0] EV_FIRED       = 3'd4;
    localparam logic [KIND_W-1:0] EV_NONE_FIRED  = 3'd5;

    typedef struct packed {
        logic [OPCODE_W-1:0]   opcode;
        logic [TIMER_ID_W-1:0] timer_id;
        logic [DELAY_W-1:0]    delay;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0]     event_kind;
        logic [TIMER_ID_W-1:0] fired_id;
        logic                  last;
    } evt_t;

endpackage

[rtl/timer_queue_with_cancel.sv]
// Top level: timer table with start, cancel and tick, expiry times kept in a RAM.
`timescale 1ns / 1ps
// Usage
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one command per transaction:
//   start a timer at now + delay, cancel a timer, or advance time by one tick.
//   evt channel (evt_valid / evt_stall / evt) returns the results. Start and cancel
//   give exactly one event; a tick gives one "fired" event per expired timer
//   (earliest expiry first, then lowest id, at most 16) or one "nothing fired".
//   The final event of every command has last set.
// Timing and throughput
//   Start and cancel: event appears the cycle after acceptance, one command per
//   cycle while the evt side drains.
//   Tick: each scan reads the expiry RAM once per timer and ends in the emit state;
//   nothing expired takes one scan. Firing k timers runs k + 1 scans; at the cap of
//   16 the closing scan is skipped. The single RAM read port paces the scans, and
//   receiver stalls lengthen a tick.
// Reset
//   Time returns to zero and every timer is idle. The RAM is not cleared; an entry's
//   contents only count while its timer is pending, so no clearing pass is needed.
// Stall
//   A stalled event is held in the output register. New commands are taken only
//   when the block is idle and the output register is empty or draining.

module timer_queue_with_cancel #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32,
    parameter int DELAY_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  tmq_pkg::cmd_t cmd,
    output logic          evt_valid,
    input  logic          evt_stall,
    output tmq_pkg::evt_t evt
);

    localparam int IW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW   = $clog2(NUM_TIMERS + 1);
    localparam int IDW  = tmq_pkg::TIMER_ID_W;
    localparam int DLW  = tmq_pkg::DELAY_W;
    localparam logic [IW-1:0] LAST_IX = IW'(NUM_TIMERS - 1);
    localparam logic [CW-1:0] NUM_T   = CW'(NUM_TIMERS);

    // One-hot sequencer states.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t                          state_reg, state_next;
    logic [TIME_BITS-1:0]            cur_reg, cur_next;
    logic [NUM_TIMERS-1:0]           pend_reg, pend_next;
    logic [CW-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic [IW-1:0]                   rd_idx_reg, rd_idx_next;
    logic                            best_found_reg, best_found_next;
    logic [TIME_BITS-1:0]            best_age_reg, best_age_next;
    logic [IW-1:0]                   best_idx_reg, best_idx_next;
    logic                            scan_found_reg, scan_found_next;
    logic [IW-1:0]                   scan_idx_reg, scan_idx_next;
    logic                            hold_vld_reg, hold_vld_next;
    logic [IW-1:0]                   hold_idx_reg, hold_idx_next;
    logic [tmq_pkg::FIRE_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;
    tmq_pkg::evt_t                   out_reg, out_next;

    // Expiry RAM: one write port (start), one registered read port (scan).
    logic [TIME_BITS-1:0]            exp_mem [NUM_TIMERS];
    logic [TIME_BITS-1:0]            rd_data_reg;
    logic                            mem_we;
    logic                            mem_re;
    logic [IW-1:0]                   mem_wa;
    logic [IW-1:0]                   mem_ra;
    logic [TIME_BITS-1:0]            mem_wd;

    logic                            out_free;
    logic                            cmd_acc;
    logic                            in_range;
    logic [IW+IDW-1:0]               id_wide;
    logic [IW-1:0]                   id_ix;
    logic [DLW-1:0]                  dly_mask;
    logic [TIME_BITS+DLW-1:0]        dly_wide;
    logic [TIME_BITS-1:0]            age;
    logic                            expired;
    logic                            better;
    logic [IDW+IW-1:0]               hold_wide;

    assign out_free  = !out_valid_reg || !evt_stall;
    assign cmd_stall = !((state_reg == S_IDLE) && out_free);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    assign in_range  = 32'(cmd.timer_id) < 32'(NUM_TIMERS);
    assign id_wide   = {{IW{1'b0}}, cmd.timer_id};
    assign id_ix     = id_wide[IW-1:0];
    assign hold_wide = {{IDW{1'b0}}, hold_idx_reg};

    // Keep only the low DELAY_BITS bits of the delay.
    always_comb
    begin
        for (int b = 0; b < DLW; b++)
        begin
            dly_mask[b] = cmd.delay[b] & (b < DELAY_BITS);
        end
    end
    assign dly_wide = {{TIME_BITS{1'b0}}, dly_mask};

    assign mem_wa = id_ix;
    assign mem_wd = cur_reg + dly_wide[TIME_BITS-1:0];
    assign mem_ra = rd_ptr_reg[IW-1:0];

    // Wrap-aware expiry test on the entry returned by the RAM.
    assign age     = cur_reg - rd_data_reg;
    assign expired = pend_reg[rd_idx_reg] && !age[TIME_BITS-1];
    assign better  = rd_vld_reg && expired && (!best_found_reg || (age > best_age_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            exp_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= exp_mem[mem_ra];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        pend_next       = pend_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_vld_next     = rd_vld_reg;
        rd_idx_next     = rd_idx_reg;
        best_found_next = best_found_reg;
        best_age_next   = best_age_reg;
        best_idx_next   = best_idx_reg;
        scan_found_next = scan_found_reg;
        scan_idx_next   = scan_idx_reg;
        hold_vld_next   = hold_vld_reg;
        hold_idx_next   = hold_idx_reg;
        cnt_next        = cnt_reg;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        out_valid_next  = out_valid_reg && evt_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    out_next.fired_id = cmd.timer_id;
                    out_next.last     = 1'b1;
                    unique case (cmd.opcode)
                        tmq_pkg::OP_START:
                        begin
                            out_valid_next = 1'b1;
                            if (!in_range)
                            begin
                                out_next.event_kind = tmq_pkg::EV_NOT_PENDING;
                            end
                            else if (pend_reg[id_ix])
                            begin
                                out_next.event_kind = tmq_pkg::EV_ALREADY;
                            end
                            else
                            begin
                                pend_next[id_ix]    = 1'b1;
                                mem_we              = 1'b1;
                                out_next.event_kind = tmq_pkg::EV_STARTED;
                            end
                        end
                        tmq_pkg::OP_CANCEL:
                        begin
                            out_valid_next = 1'b1;
                            if (in_range && pend_reg[id_ix])
                            begin
                                pend_next[id_ix]    = 1'b0;
                                out_next.event_kind = tmq_pkg::EV_CANCELLED;
                            end
                            else
                            begin
                                out_next.event_kind = tmq_pkg::EV_NOT_PENDING;
                            end
                        end
                        tmq_pkg::OP_TICK:
                        begin
                            // Advance time, then start the first scan.
                            cur_next        = cur_reg + TIME_BITS'(1);
                            rd_ptr_next     = '0;
                            rd_vld_next     = 1'b0;
                            best_found_next = 1'b0;
                            hold_vld_next   = 1'b0;
                            cnt_next        = '0;
                            state_next      = S_SCAN;
                        end
                        tmq_pkg::OP_RSVD:
                        begin
                            // Drop: no state change, no event.
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                mem_re      = rd_ptr_reg < NUM_T;
                rd_vld_next = mem_re;
                rd_idx_next = rd_ptr_reg[IW-1:0];
                if (mem_re)
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
                if (better)
                begin
                    best_found_next = 1'b1;
                    best_age_next   = age;
                    best_idx_next   = rd_idx_reg;
                end
                if (rd_vld_reg && (rd_idx_reg == LAST_IX))
                begin
                    scan_found_next = best_found_reg || better;
                    scan_idx_next   = better ? rd_idx_reg : best_idx_reg;
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (hold_vld_reg)
                begin
                    // Release the held timer; it is final unless this scan found more.
                    if (out_free)
                    begin
                        out_valid_next      = 1'b1;
                        out_next.event_kind = tmq_pkg::EV_FIRED;
                        out_next.fired_id   = hold_wide[IDW-1:0];
                        out_next.last       = !scan_found_reg;
                        hold_vld_next       = 1'b0;
                        if (!scan_found_reg)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (scan_found_reg)
                begin
                    // Clear and hold the winner; a next scan, if any, tells if it is last.
                    pend_next[scan_idx_reg] = 1'b0;
                    hold_vld_next           = 1'b1;
                    hold_idx_next           = scan_idx_reg;
                    scan_found_next         = 1'b0;
                    cnt_next                = cnt_reg + tmq_pkg::FIRE_CNT_W'(1);
                    if (cnt_reg != tmq_pkg::FIRE_CNT_W'(tmq_pkg::MAX_FIRE - 1))
                    begin
                        rd_ptr_next     = '0;
                        rd_vld_next     = 1'b0;
                        best_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.event_kind = tmq_pkg::EV_NONE_FIRED;
                    out_next.fired_id   = '0;
                    out_next.last       = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            pend_reg       <= '0;
            rd_ptr_reg     <= '0;
            rd_vld_reg     <= 1'b0;
            best_found_reg <= 1'b0;
            scan_found_reg <= 1'b0;
            hold_vld_reg   <= 1'b0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            pend_reg       <= pend_next;
            rd_ptr_reg     <= rd_ptr_next;
            rd_vld_reg     <= rd_vld_next;
            best_found_reg <= best_found_next;
            scan_found_reg <= scan_found_next;
            hold_vld_reg   <= hold_vld_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        best_age_reg <= best_age_next;
        best_idx_reg <= best_idx_next;
        scan_idx_reg <= scan_idx_next;
        hold_idx_reg <= hold_idx_next;
        out_reg      <= out_next;
    end

endmodule

[rtl/tmq_checker.sv]
// Checker: port-level assertions for the timer queue, bound to the top level.
`timescale 1ns / 1ps

module tmq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input tmq_pkg::cmd_t cmd,
    input logic          evt_valid,
    input logic          evt_stall,
    input tmq_pkg::evt_t evt
);

    // Hold a stalled event unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt_stall |=> evt_valid && $stable(evt))
    else $error("stalled event changed");

    // Answer a start or cancel with an event on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall &&
        (cmd.opcode == tmq_pkg::OP_START || cmd.opcode == tmq_pkg::OP_CANCEL)
        |=> evt_valid)
    else $error("start or cancel gave no event");

    // Block new commands while a tick is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && cmd.opcode == tmq_pkg::OP_TICK |=> cmd_stall)
    else $error("command taken during tick scan");

    // Every event other than a fired timer ends its command.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && evt.event_kind != tmq_pkg::EV_FIRED |-> evt.last)
    else $error("single event without last");

    // Report only defined event kinds.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> evt.event_kind <= tmq_pkg::EV_NONE_FIRED)
    else $error("undefined event kind");

endmodule

bind timer_queue_with_cancel tmq_checker u_tmq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
);
